// File: hw/rtl/dd_odo_pkg.sv
package dd_odo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int COUNT_W   = 32;
  localparam int POS_W     = 48;
  localparam int ANGLE_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int ATAN_IDX_W = 5;

  localparam logic [CFG_W-1:0] DPC_RESET = 32'd65536;
  localparam logic [CFG_W-1:0] HPC_RESET = 32'd0;

  // CORDIC start value 0.607252935 in Q30
  localparam longint GAIN_Q30 = 64'sd652032875;

  // Register index, taken from paddr[2]
  localparam logic REG_DPC = 1'b0;
  localparam logic REG_HPC = 1'b1;

  // atan(2^-i) in binary angle units, 2^32 a full turn
  function automatic logic [30:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd536870912;
      5'd1:  v = 31'd316933406;
      5'd2:  v = 31'd167458907;
      5'd3:  v = 31'd85004756;
      5'd4:  v = 31'd42667331;
      5'd5:  v = 31'd21354465;
      5'd6:  v = 31'd10679838;
      5'd7:  v = 31'd5340245;
      5'd8:  v = 31'd2670163;
      5'd9:  v = 31'd1335087;
      5'd10: v = 31'd667544;
      5'd11: v = 31'd333772;
      5'd12: v = 31'd166886;
      5'd13: v = 31'd83443;
      5'd14: v = 31'd41722;
      5'd15: v = 31'd20861;
      5'd16: v = 31'd10430;
      5'd17: v = 31'd5215;
      5'd18: v = 31'd2608;
      5'd19: v = 31'd1304;
      5'd20: v = 31'd652;
      5'd21: v = 31'd326;
      5'd22: v = 31'd163;
      5'd23: v = 31'd81;
      5'd24: v = 31'd41;
      5'd25: v = 31'd20;
      5'd26: v = 31'd10;
      5'd27: v = 31'd5;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/dd_odo_if.sv
interface dd_odo_sample_if import dd_odo_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] left_count;
  logic signed [COUNT_W-1:0] right_count;
  logic                      clear;

  modport source(output valid, left_count, right_count, clear, input ready);
  modport sink(input valid, left_count, right_count, clear, output ready);
endinterface

interface dd_odo_pose_if import dd_odo_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANGLE_W-1:0]      heading;

  modport source(output valid, pos_x, pos_y, heading, input ready);
  modport sink(input valid, pos_x, pos_y, heading, output ready);
endinterface

// File: hw/rtl/dd_odo_smul.sv
module dd_odo_smul import dd_odo_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 33
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            busy,
  output logic [AW+BW-1:0] p
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] prod;
  logic [AW:0]      sum;
  logic [CW-1:0]    cnt;

  // One multiplier bit per cycle, least significant first; the low part of
  // the product shifts in behind the multiplier bits.
  always_comb begin
    sum = {1'b0, prod[AW+BW-1:BW]} + (prod[0] ? {1'b0, a_r} : {(AW+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(BW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      prod <= {{AW{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[BW-1:1]};
    end
  end

  assign p = prod;

endmodule

// File: hw/rtl/dd_odo_cordic.sv
module dd_odo_cordic import dd_odo_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC  = FRAC_BITS_DEF,
  localparam int W    = FRAC + 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ANGLE_W-1:0] angle,
  output logic               busy,
  output logic signed [W-1:0] cos_v,
  output logic signed [W-1:0] sin_v
);

  localparam longint X0 = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
  localparam int ZW = ANGLE_W + 2;

  logic signed [W-1:0]  x, y, xs, ys;
  logic signed [ZW-1:0] z, at;
  logic [ATAN_IDX_W-1:0] idx;
  logic                  flip;

  always_comb begin
    xs = x >>> idx;
    ys = y >>> idx;
    at = signed'({3'b000, atan_entry(idx)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      idx <= idx + 1'b1;
      if (idx == ATAN_IDX_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Angles in the left half-plane are turned by half a turn first and the
  // results negated at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= angle[31] ^ angle[30];
      z    <= ZW'(signed'({angle[31] ^ angle[30] ^ angle[31], angle[30:0]}));
      x    <= W'(X0);
      y    <= '0;
    end else if (busy) begin
      if (!z[ZW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign cos_v = flip ? -x : x;
  assign sin_v = flip ? -y : y;

endmodule

// File: hw/rtl/differential_drive_odometry.sv
// Channel  Dir  Payload                              Transfer when
// sample   in   left_count, right_count, clear       sample.valid && sample.ready
// pose     out  pos_x, pos_y, heading                pose.valid && pose.ready
// apb      in   distance_per_count (0x0),            psel && penable && pwrite
//               heading_per_count_difference (0x4)
//
// Each item runs through PREP, MAG, SCALE, UPDATE and OUT: in MAG the
// bit-serial travel multiply, with the CORDIC running alongside, then in
// SCALE the two bit-serial cosine and sine scalings. A clear item goes
// from PREP straight to OUT. Reset is synchronous and clears the pose.
// A pose waiting in the output register does not stop the next sample being
// taken; only the write of the next pose waits for it.
module differential_drive_odometry import dd_odo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]      pwdata,
  output logic [CFG_W-1:0]      prdata,
  output logic                  pready,
  dd_odo_sample_if.sink         sample,
  dd_odo_pose_if.source         pose
);

  localparam int TW  = FRAC_BITS + 3;
  localparam int SBW = TW - 1;
  localparam int MW  = 64;
  localparam int SPW = MW + SBW;
  localparam int QW  = SPW - FRAC_BITS - 1;
  localparam int DW  = POS_W + 1;
  localparam int AW  = POS_W + 2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PREP   = 6'b000010,
    S_MAG    = 6'b000100,
    S_SCALE  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] dpc, hpc;
  logic [COUNT_W-1:0] last_left, last_right, lc_r, rc_r;
  logic clr_r;
  logic signed [POS_W-1:0] x_acc, y_acc;
  logic [ANGLE_W-1:0] head;

  logic [COUNT_W-1:0] ul, ur, diff, hprod, hstep;
  logic signed [COUNT_W:0] dsum, dabs;
  logic hchange, mag_neg, cneg, sneg;

  logic mag_start, mag_busy, scl_start, xs_busy, ys_busy, cor_busy;
  logic [COUNT_W+COUNT_W:0] mag_p;
  logic signed [TW-1:0] cos_v, sin_v, cabs, sabs;
  logic [SPW-1:0] xp, yp;
  logic [DW-1:0] dx, dy;
  logic signed [POS_W-1:0] x_new, y_new;

  logic out_valid;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [ANGLE_W-1:0] out_h;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HPC) ? hpc : dpc;

  always_ff @(posedge clk) begin
    if (rst) begin
      dpc <= DPC_RESET;
      hpc <= HPC_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DPC) begin
        dpc <= pwdata;
      end else begin
        hpc <= pwdata;
      end
    end
  end

  // Count deltas, wrapped to 32 bits
  always_comb begin
    ul    = lc_r - last_left;
    ur    = rc_r - last_right;
    diff  = ul - ur;
    hprod = diff * hpc;
    dsum  = signed'({ul[COUNT_W-1], ul}) + signed'({ur[COUNT_W-1], ur});
    dabs  = dsum[COUNT_W] ? -dsum : dsum;
  end

  assign mag_start = (state == S_PREP) && !clr_r;
  assign scl_start = (state == S_MAG) && !mag_busy && !cor_busy;

  dd_odo_smul #(.AW(COUNT_W), .BW(COUNT_W + 1)) u_mag (
    .clk(clk), .rst(rst), .start(mag_start), .a(dpc), .b(dabs),
    .busy(mag_busy), .p(mag_p)
  );

  dd_odo_cordic #(.STEPS(CORDIC_STEPS), .FRAC(FRAC_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(mag_start), .angle(head),
    .busy(cor_busy), .cos_v(cos_v), .sin_v(sin_v)
  );

  assign cabs = cos_v[TW-1] ? -cos_v : cos_v;
  assign sabs = sin_v[TW-1] ? -sin_v : sin_v;

  dd_odo_smul #(.AW(MW), .BW(SBW)) u_xscale (
    .clk(clk), .rst(rst), .start(scl_start), .a(mag_p[MW-1:0]), .b(cabs[SBW-1:0]),
    .busy(xs_busy), .p(xp)
  );

  dd_odo_smul #(.AW(MW), .BW(SBW)) u_yscale (
    .clk(clk), .rst(rst), .start(scl_start), .a(mag_p[MW-1:0]), .b(sabs[SBW-1:0]),
    .busy(ys_busy), .p(yp)
  );

  function automatic logic [DW-1:0] cap_step(input logic [QW-1:0] q);
    logic [QW-1:0] lim;
    lim = QW'(1) << POS_W;
    return (q > lim) ? lim[DW-1:0] : q[DW-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] advance(
    input logic signed [POS_W-1:0] acc, input logic [DW-1:0] d, input logic neg);
    logic signed [AW-1:0] s;
    s = neg ? (AW'(acc) - signed'({1'b0, d})) : (AW'(acc) + signed'({1'b0, d}));
    if (s[AW-1:POS_W-1] != {(AW - POS_W + 1){s[AW-1]}}) begin
      return s[AW-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return s[POS_W-1:0];
  endfunction

  assign dx    = cap_step(xp[SPW-1:FRAC_BITS+1]);
  assign dy    = cap_step(yp[SPW-1:FRAC_BITS+1]);
  assign x_new = advance(x_acc, dx, mag_neg ^ cneg);
  assign y_new = advance(y_acc, dy, mag_neg ^ sneg);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (sample.valid) state_next = S_PREP;
      S_PREP:   state_next = clr_r ? S_OUT : S_MAG;
      S_MAG:    if (!mag_busy && !cor_busy) state_next = S_SCALE;
      S_SCALE:  if (!xs_busy && !ys_busy) state_next = S_UPDATE;
      S_UPDATE: state_next = S_OUT;
      S_OUT:    if (!out_valid || pose.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      lc_r  <= sample.left_count;
      rc_r  <= sample.right_count;
      clr_r <= sample.clear;
    end
    if (state == S_PREP) begin
      mag_neg <= dsum[COUNT_W];
      hstep   <= hprod;
      hchange <= (ul != ur);
    end
    if (scl_start) begin
      cneg <= cos_v[TW-1];
      sneg <= sin_v[TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
      x_acc      <= '0;
      y_acc      <= '0;
      head       <= '0;
    end else if (state == S_PREP) begin
      last_left  <= lc_r;
      last_right <= rc_r;
      if (clr_r) begin
        x_acc <= '0;
        y_acc <= '0;
        head  <= '0;
      end
    end else if (state == S_UPDATE) begin
      x_acc <= x_new;
      y_acc <= y_new;
      if (hchange) begin
        head <= head + hstep;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || pose.ready)) begin
      out_valid <= 1'b1;
    end else if (pose.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || pose.ready)) begin
      out_x <= x_acc;
      out_y <= y_acc;
      out_h <= head;
    end
  end

  assign pose.valid   = out_valid;
  assign pose.pos_x   = out_x;
  assign pose.pos_y   = out_y;
  assign pose.heading = out_h;

endmodule
